// File: rtl/core/usb_config_descriptor_endpoint_parser_defines.svh
// Assertion macros for the descriptor endpoint parser checker.
// Depends on clk and rst_n being visible where the macros expand.
`ifndef USB_CONFIG_DESCRIPTOR_ENDPOINT_PARSER_DEFINES_SVH
`define USB_CONFIG_DESCRIPTOR_ENDPOINT_PARSER_DEFINES_SVH

// same-cycle implication
`define UCDEP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define UCDEP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/ucdep_pkg.sv
// Types and constants shared by the descriptor endpoint parser modules.
// No dependencies.
package ucdep_pkg;

    localparam int MAX_INTERFACES   = 8;
    localparam int MAX_IN_ENDPOINTS = 4;
    localparam int MAX_TOTAL_LENGTH = 512;

    localparam logic [8:0]  MAX_IF_LIMIT  = 9'(MAX_INTERFACES);
    localparam logic [4:0]  MAX_EP_LIMIT  = 5'(MAX_IN_ENDPOINTS);
    localparam logic [15:0] MAX_TOTAL_LEN = 16'(MAX_TOTAL_LENGTH);

    localparam logic [7:0] DEFAULT_CLASS = 8'h03;

    localparam logic [7:0] TYPE_CONFIG    = 8'h02;
    localparam logic [7:0] TYPE_INTERFACE = 8'h04;
    localparam logic [7:0] TYPE_ENDPOINT  = 8'h05;

    localparam logic [15:0] POS_LEN_LOW  = 16'd2;
    localparam logic [15:0] POS_LEN_HIGH = 16'd3;

    localparam logic [7:0] OFF_LENGTH    = 8'd0;
    localparam logic [7:0] OFF_TYPE      = 8'd1;
    localparam logic [7:0] OFF_EP_ADDR   = 8'd2;
    localparam logic [7:0] OFF_NUM_IF    = 8'd4;
    localparam logic [7:0] OFF_EP_MPS    = 8'd4;
    localparam logic [7:0] OFF_IF_CLASS  = 8'd5;
    localparam logic [7:0] OFF_EP_IVL    = 8'd6;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_ZERO_LEN = 2'd1;
    localparam logic [1:0] STATUS_DROPPED  = 2'd2;

    localparam logic KIND_ENDPOINT = 1'b0;
    localparam logic KIND_SUMMARY  = 1'b1;

    typedef struct packed {
        logic       entry_kind;
        logic [2:0] interface_index;
        logic [1:0] endpoint_slot;
        logic [6:0] endpoint_number;
        logic [7:0] max_packet_low;
        logic [7:0] poll_interval;
        logic [7:0] declared_interfaces;
        logic [1:0] parse_status;
        logic       last_of_run;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first_word;
        result_t    second_word;
    } push_t;

endpackage

// File: rtl/core/ucdep_parser.sv
// Descriptor walker: parse state and the per-byte decode into result words.
// Depends on ucdep_pkg.
module ucdep_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       data_byte,
    input  logic             first_byte,
    input  logic [7:0]       accepted_class,
    output ucdep_pkg::push_t push
);
    import ucdep_pkg::*;

    logic [15:0] wtotal_reg, wtotal_next, wtotal_cur;
    logic [15:0] pos_reg, pos_next, pos_cur;
    logic [7:0]  off_reg, off_next, off_cur;
    logic [7:0]  len_reg, len_next, len_cur;
    logic [7:0]  type_reg, type_next, type_cur;
    logic        inside_reg, inside_next, inside_cur;
    logic [7:0]  if_cnt_reg, if_cnt_next, if_cnt_cur;
    logic [2:0]  ep_cnt_reg, ep_cnt_next, ep_cnt_cur;
    logic [7:0]  ep_addr_reg, ep_addr_next, ep_addr_cur;
    logic [7:0]  pkt_low_reg, pkt_low_next, pkt_low_cur;
    logic [7:0]  num_if_reg, num_if_next, num_if_cur;
    logic [1:0]  status_reg, status_next, status_cur;
    logic        done_reg, done_next;
    logic        active;
    logic [15:0] len_word;
    logic [8:0]  off_inc;
    logic [16:0] pos_inc;
    logic        entry_hit;
    logic        sum_hit;
    result_t     entry_word;
    result_t     sum_word;

    assign active = step && (first_byte || !done_reg);

    assign wtotal_cur    = first_byte ? '0 : wtotal_reg;
    assign pos_cur       = first_byte ? '0 : pos_reg;
    assign off_cur       = first_byte ? '0 : off_reg;
    assign len_cur       = first_byte ? '0 : len_reg;
    assign type_cur      = first_byte ? '0 : type_reg;
    assign inside_cur    = first_byte ? 1'b0 : inside_reg;
    assign if_cnt_cur    = first_byte ? '0 : if_cnt_reg;
    assign ep_cnt_cur    = first_byte ? '0 : ep_cnt_reg;
    assign ep_addr_cur   = first_byte ? '0 : ep_addr_reg;
    assign pkt_low_cur   = first_byte ? '0 : pkt_low_reg;
    assign num_if_cur    = first_byte ? '0 : num_if_reg;
    assign status_cur    = first_byte ? STATUS_OK : status_reg;

    assign len_word = {data_byte, wtotal_cur[7:0]};

    always_comb
    begin
        wtotal_next    = wtotal_cur;
        len_next       = len_cur;
        type_next      = type_cur;
        inside_next    = inside_cur;
        if_cnt_next    = if_cnt_cur;
        ep_cnt_next    = ep_cnt_cur;
        ep_addr_next   = ep_addr_cur;
        pkt_low_next   = pkt_low_cur;
        num_if_next    = num_if_cur;
        status_next    = status_cur;
        done_next      = 1'b0;
        entry_hit      = 1'b0;
        sum_hit        = 1'b0;
        entry_word     = '0;
        entry_word.entry_kind = KIND_ENDPOINT;

        if (pos_cur == POS_LEN_LOW)
        begin
            wtotal_next = {8'd0, data_byte};
        end
        else if (pos_cur == POS_LEN_HIGH)
        begin
            wtotal_next = (len_word > MAX_TOTAL_LEN) ? MAX_TOTAL_LEN : len_word;
        end

        if (off_cur == OFF_LENGTH)
        begin
            len_next  = data_byte;
            type_next = '0;
        end
        else if (off_cur == OFF_TYPE)
        begin
            type_next = data_byte;
            if (data_byte == TYPE_INTERFACE)
            begin
                inside_next = 1'b0;
                ep_cnt_next = '0;
                if (if_cnt_cur != 8'hFF)
                begin
                    if_cnt_next = if_cnt_cur + 8'd1;
                end
            end
        end
        else if (type_cur == TYPE_CONFIG)
        begin
            if (off_cur == OFF_NUM_IF && !inside_cur)
            begin
                num_if_next = data_byte;
            end
        end
        else if (type_cur == TYPE_INTERFACE)
        begin
            if (off_cur == OFF_IF_CLASS)
            begin
                inside_next = (data_byte == accepted_class);
            end
        end
        else if (type_cur == TYPE_ENDPOINT && inside_cur)
        begin
            if (off_cur == OFF_EP_ADDR)
            begin
                ep_addr_next = data_byte;
            end
            else if (off_cur == OFF_EP_MPS)
            begin
                pkt_low_next = data_byte;
            end
            else if (off_cur == OFF_EP_IVL && ep_addr_cur[7])
            begin
                if (if_cnt_cur != '0 && {1'b0, if_cnt_cur} <= MAX_IF_LIMIT
                    && {2'b00, ep_cnt_cur} < MAX_EP_LIMIT)
                begin
                    entry_hit = 1'b1;
                    entry_word.interface_index = if_cnt_cur[2:0] - 3'd1;
                    entry_word.endpoint_slot   = ep_cnt_cur[1:0];
                    entry_word.endpoint_number = ep_addr_cur[6:0];
                    entry_word.max_packet_low  = pkt_low_cur;
                    entry_word.poll_interval   = data_byte;
                end
                else
                begin
                    status_next = STATUS_DROPPED;
                end
                if (ep_cnt_cur != 3'd7)
                begin
                    ep_cnt_next = ep_cnt_cur + 3'd1;
                end
            end
        end

        if (off_cur == OFF_LENGTH && data_byte == 8'd0)
        begin
            status_next = STATUS_ZERO_LEN;
            sum_hit     = 1'b1;
        end
        else if (pos_cur >= POS_LEN_HIGH && pos_inc >= {1'b0, wtotal_next})
        begin
            sum_hit = 1'b1;
        end
        done_next = sum_hit;
    end

    assign off_inc  = {1'b0, off_cur} + 9'd1;
    assign off_next = (off_inc >= {1'b0, len_next}) ? '0 : off_inc[7:0];
    assign pos_inc  = {1'b0, pos_cur} + 17'd1;
    assign pos_next = pos_inc[15:0];

    always_comb
    begin
        sum_word = '0;
        sum_word.entry_kind          = KIND_SUMMARY;
        sum_word.declared_interfaces = num_if_next;
        sum_word.parse_status        = status_next;
        sum_word.last_of_run         = 1'b1;
    end

    always_comb
    begin
        push = '0;
        if (active)
        begin
            if (entry_hit && sum_hit)
            begin
                push.count       = 2'd2;
                push.first_word  = entry_word;
                push.second_word = sum_word;
            end
            else if (entry_hit)
            begin
                push.count                  = 2'd1;
                push.first_word             = entry_word;
                push.first_word.last_of_run = 1'b1;
            end
            else if (sum_hit)
            begin
                push.count      = 2'd1;
                push.first_word = sum_word;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wtotal_reg    <= '0;
            pos_reg       <= '0;
            off_reg       <= '0;
            len_reg       <= '0;
            type_reg      <= '0;
            inside_reg    <= 1'b0;
            if_cnt_reg    <= '0;
            ep_cnt_reg    <= '0;
            ep_addr_reg   <= '0;
            pkt_low_reg   <= '0;
            num_if_reg    <= '0;
            status_reg    <= STATUS_OK;
            done_reg      <= 1'b1;
        end
        else if (active)
        begin
            wtotal_reg    <= wtotal_next;
            pos_reg       <= pos_next;
            off_reg       <= off_next;
            len_reg       <= len_next;
            type_reg      <= type_next;
            inside_reg    <= inside_next;
            if_cnt_reg    <= if_cnt_next;
            ep_cnt_reg    <= ep_cnt_next;
            ep_addr_reg   <= ep_addr_next;
            pkt_low_reg   <= pkt_low_next;
            num_if_reg    <= num_if_next;
            status_reg    <= status_next;
            done_reg      <= done_next;
        end
    end

endmodule

// File: rtl/core/ucdep_fifo.sv
// Four-word result queue, takes up to two words per cycle, gives one.
// Depends on ucdep_pkg.
module ucdep_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  ucdep_pkg::push_t  push,
    input  logic              pop,
    output logic              has_room,
    output logic              not_empty,
    output ucdep_pkg::result_t head
);
    import ucdep_pkg::*;

    localparam int DEPTH = 4;

    result_t    mem [DEPTH];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic [1:0] wr_ptr_second;

    assign has_room      = count_reg <= 3'd2;
    assign not_empty     = count_reg != 3'd0;
    assign head          = mem[rd_ptr_reg];
    assign wr_ptr_second = wr_ptr_reg + 2'd1;
    assign wr_ptr_next   = wr_ptr_reg + push.count;
    assign rd_ptr_next   = rd_ptr_reg + {1'b0, pop};
    assign count_next    = count_reg + {1'b0, push.count} - {2'b00, pop};

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first_word;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_second] <= push.second_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/core/usb_config_descriptor_endpoint_parser.sv
// Top level of the descriptor endpoint parser: input word register, class register.
// Depends on ucdep_pkg, ucdep_parser and ucdep_fifo.
//
//   channel | handshake             | payload
//   in      | in_valid / in_stall   | data_byte, first_byte
//   out     | out_valid / out_stall | entry_kind .. last_of_run
//   cfg     | cfg_wr_en             | cfg_wr_data (interface class)
//
// One byte per cycle while in_stall is low; a byte waits in the input register
// until the queue has room, then its results land in the queue and show at its head.
// A byte may give two words (entry, summary); the four-word queue absorbs them.
// in_stall rises while a byte waits in the input register and the queue
// holds more than two words.
// Reset clears the parser to idle and the class to 3; no clearing pass.
module usb_config_descriptor_endpoint_parser (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       first_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       entry_kind,
    output logic [2:0] interface_index,
    output logic [1:0] endpoint_slot,
    output logic [6:0] endpoint_number,
    output logic [7:0] max_packet_low,
    output logic [7:0] poll_interval,
    output logic [7:0] declared_interfaces,
    output logic [1:0] parse_status,
    output logic       last_of_run
);
    import ucdep_pkg::*;

    logic [7:0] accepted_class_reg;
    logic       stage_valid_reg, stage_valid_next;
    logic [7:0] stage_byte_reg;
    logic       stage_first_reg;
    logic       has_room;
    logic       advance;
    logic       accept;
    logic       pop;
    push_t      push;
    result_t    head;

    assign advance          = stage_valid_reg && has_room;
    assign in_stall         = stage_valid_reg && !has_room;
    assign accept           = in_valid && !in_stall;
    assign pop              = out_valid && !out_stall;
    assign stage_valid_next = accept || (stage_valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accepted_class_reg <= DEFAULT_CLASS;
            stage_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                accepted_class_reg <= cfg_wr_data;
            end
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_byte_reg  <= data_byte;
            stage_first_reg <= first_byte;
        end
    end

    ucdep_parser u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (advance),
        .data_byte      (stage_byte_reg),
        .first_byte     (stage_first_reg),
        .accepted_class (accepted_class_reg),
        .push           (push)
    );

    ucdep_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (pop),
        .has_room  (has_room),
        .not_empty (out_valid),
        .head      (head)
    );

    assign entry_kind          = head.entry_kind;
    assign interface_index     = head.interface_index;
    assign endpoint_slot       = head.endpoint_slot;
    assign endpoint_number     = head.endpoint_number;
    assign max_packet_low      = head.max_packet_low;
    assign poll_interval       = head.poll_interval;
    assign declared_interfaces = head.declared_interfaces;
    assign parse_status        = head.parse_status;
    assign last_of_run         = head.last_of_run;

endmodule

// File: rtl/core/ucdep_checker.sv
// Port-level checks for the descriptor endpoint parser, bound to the top level.
// Depends on usb_config_descriptor_endpoint_parser_defines.svh.
`include "usb_config_descriptor_endpoint_parser_defines.svh"

module ucdep_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       cfg_wr_en,
    input logic [7:0] cfg_wr_data,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] data_byte,
    input logic       first_byte,
    input logic       out_valid,
    input logic       out_stall,
    input logic       entry_kind,
    input logic [2:0] interface_index,
    input logic [1:0] endpoint_slot,
    input logic [6:0] endpoint_number,
    input logic [7:0] max_packet_low,
    input logic [7:0] poll_interval,
    input logic [7:0] declared_interfaces,
    input logic [1:0] parse_status,
    input logic       last_of_run
);

    `UCDEP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(entry_kind) && $stable(parse_status) && $stable(poll_interval), "stalled word changed")

    `UCDEP_ASSERT_NOW(a_summary_shape, out_valid && entry_kind, last_of_run && interface_index == 3'd0 && endpoint_slot == 2'd0 && endpoint_number == 7'd0 && max_packet_low == 8'd0 && poll_interval == 8'd0 && parse_status != 2'd3, "malformed summary word")

    `UCDEP_ASSERT_NOW(a_entry_shape, out_valid && !entry_kind, declared_interfaces == 8'd0 && parse_status == 2'd0, "malformed endpoint word")

    `UCDEP_ASSERT_NEXT(a_entry_then_summary, out_valid && !out_stall && !entry_kind && !last_of_run, out_valid && entry_kind, "entry not followed by its summary")

endmodule

bind usb_config_descriptor_endpoint_parser ucdep_checker u_ucdep_checker (.*);
